// ===== src/gpe_pkg.sv =====
// Shared types, register codes and pin masks of the GPIO port with edge interrupts.
// No dependencies; every module of the block imports this package.
`default_nettype none

package gpe_pkg;

    // Number of pins that are present; pins at or above it read as zero.
    localparam int PIN_COUNT = 16;

    // Request commands
    localparam logic [1:0] CMD_READ   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;

    // Register map
    localparam logic [3:0] REG_MODE    = 4'd0;
    localparam logic [3:0] REG_OTYPE   = 4'd1;
    localparam logic [3:0] REG_SPEED   = 4'd2;
    localparam logic [3:0] REG_PULL    = 4'd3;
    localparam logic [3:0] REG_INPUT   = 4'd4;
    localparam logic [3:0] REG_OUTPUT  = 4'd5;
    localparam logic [3:0] REG_ALT_LO  = 4'd6;
    localparam logic [3:0] REG_ALT_HI  = 4'd7;
    localparam logic [3:0] REG_RISE    = 4'd8;
    localparam logic [3:0] REG_FALL    = 4'd9;
    localparam logic [3:0] REG_MASK    = 4'd10;
    localparam logic [3:0] REG_PENDING = 4'd11;

    // Mode field value that selects general-purpose output
    localparam logic [1:0] MODE_OUTPUT = 2'b01;

    // Build a mask with 'bits' ones per present pin, starting at pin 'first'
    function automatic logic [31:0] field_mask(input int bits, input int first);
        logic [31:0] ones;
        logic [31:0] m;
        ones = (32'd1 << bits) - 32'd1;
        m = '0;
        for (int i = 0; i < 32; i++) begin
            if ((i * bits < 32) && (first + i < PIN_COUNT)) begin
                m = m | (ones << (i * bits));
            end
        end
        return m;
    endfunction

    localparam logic [31:0] PIN_MASK32   = field_mask(1, 0);
    localparam logic [15:0] PIN_MASK     = PIN_MASK32[15:0];
    localparam logic [31:0] FIELD2_MASK  = field_mask(2, 0);
    localparam logic [31:0] ALT_LO_MASK  = field_mask(4, 0);
    localparam logic [31:0] ALT_HI_MASK  = field_mask(4, 8);

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  reg_index;
        logic [31:0] write_data;
        logic [15:0] pin_levels;
    } gpe_req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] pin_drive;
        logic [15:0] drive_enable;
        logic        irq;
    } gpe_rsp_t;

endpackage

`default_nettype wire

// ===== src/gpio_port_edge_interrupt_core.sv =====
// Top level of the 16-pin GPIO port with edge interrupts: handshake and result register.
// Depends on gpe_pkg and gpe_regs.
//
// Usage: each request on req (valid/stall) is a register read, a register write or
// a pin-sample tick. Every request yields exactly one result on rsp (valid/stall),
// carrying read data (zero unless a read), the pin drive word, the drive enables
// and the interrupt line, all taken from the state after the request is applied.
// The result is registered and is valid the cycle after the request is accepted.
// Throughput: one request per cycle while req_stall is low; the register state
// updates at the accepting edge, so the next request sees it at once.
// Stall: the single result register holds a waiting result while rsp_stall is high;
// req_stall is raised only while that register is full and stalled, and clears in
// the same cycle the receiver takes the result.
// Reset: rst_n clears all registers to zero (all pins input, all interrupts
// masked, nothing pending) and empties the result register.
`default_nettype none

module gpio_port_edge_interrupt_core
    import gpe_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire gpe_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output gpe_rsp_t      rsp
);

    logic     accept;
    logic     rsp_valid_reg, rsp_valid_next;
    gpe_rsp_t rsp_reg;
    gpe_rsp_t result;

    // Stall new requests only while a result waits on a stalled receiver
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    gpe_regs u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .apply  (accept),
        .req    (req),
        .result (result)
    );

    // Advance the result register
    always_comb
    begin
        if (accept)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rsp_reg <= result;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Every accepted request shows a result next cycle
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid)
        else $error("accepted request produced no result");

    // A waiting, stalled result blocks new requests
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |-> req_stall)
        else $error("request accepted over a stalled result");

    // Hold a stalled result unchanged
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled result changed or dropped");

endmodule

`default_nettype wire

// ===== src/gpe_regs.sv =====
// GPIO port register file and edge detector; one request per cycle while apply is high.
// Depends on gpe_pkg for the request and result types, register codes and masks.
`default_nettype none

module gpe_regs
    import gpe_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     apply,
    input  wire gpe_req_t req,
    output gpe_rsp_t      result
);

    logic [31:0] mode_reg,    mode_next;
    logic [15:0] otype_reg,   otype_next;
    logic [31:0] speed_reg,   speed_next;
    logic [31:0] pull_reg,    pull_next;
    logic [15:0] input_reg,   input_next;
    logic [15:0] output_reg,  output_next;
    logic [31:0] alt_lo_reg,  alt_lo_next;
    logic [31:0] alt_hi_reg,  alt_hi_next;
    logic [15:0] rise_reg,    rise_next;
    logic [15:0] fall_reg,    fall_next;
    logic [15:0] mask_reg,    mask_next;
    logic [15:0] pending_reg, pending_next;
    logic [15:0] prev_reg,    prev_next;

    logic [15:0] levels;
    logic [15:0] wdata16;
    logic [31:0] rdata;
    logic [15:0] enables;

    assign levels  = req.pin_levels & PIN_MASK;
    assign wdata16 = req.write_data[15:0] & PIN_MASK;

    // Work out the state after this request
    always_comb
    begin
        mode_next    = mode_reg;
        otype_next   = otype_reg;
        speed_next   = speed_reg;
        pull_next    = pull_reg;
        input_next   = input_reg;
        output_next  = output_reg;
        alt_lo_next  = alt_lo_reg;
        alt_hi_next  = alt_hi_reg;
        rise_next    = rise_reg;
        fall_next    = fall_reg;
        mask_next    = mask_reg;
        pending_next = pending_reg;
        prev_next    = prev_reg;
        if (apply && (req.command == CMD_WRITE))
        begin
            case (req.reg_index)
                REG_MODE:    mode_next    = req.write_data & FIELD2_MASK;
                REG_OTYPE:   otype_next   = wdata16;
                REG_SPEED:   speed_next   = req.write_data & FIELD2_MASK;
                REG_PULL:    pull_next    = req.write_data & FIELD2_MASK;
                REG_OUTPUT:  output_next  = wdata16;
                REG_ALT_LO:  alt_lo_next  = req.write_data & ALT_LO_MASK;
                REG_ALT_HI:  alt_hi_next  = req.write_data & ALT_HI_MASK;
                REG_RISE:    rise_next    = wdata16;
                REG_FALL:    fall_next    = wdata16;
                REG_MASK:    mask_next    = wdata16;
                REG_PENDING: pending_next = pending_reg & ~wdata16;
                default:     ;
            endcase
        end
        else if (apply && (req.command == CMD_SAMPLE))
        begin
            // Latch pins and flag selected edges against the previous sample
            pending_next = pending_reg
                         | (levels & ~prev_reg & rise_reg)
                         | (~levels & prev_reg & fall_reg);
            prev_next    = levels;
            input_next   = levels;
        end
    end

    // Read mux; reads leave the state untouched
    always_comb
    begin
        rdata = '0;
        if (req.command == CMD_READ)
        begin
            case (req.reg_index)
                REG_MODE:    rdata = mode_reg;
                REG_OTYPE:   rdata = {16'd0, otype_reg};
                REG_SPEED:   rdata = speed_reg;
                REG_PULL:    rdata = pull_reg;
                REG_INPUT:   rdata = {16'd0, input_reg};
                REG_OUTPUT:  rdata = {16'd0, output_reg};
                REG_ALT_LO:  rdata = alt_lo_reg;
                REG_ALT_HI:  rdata = alt_hi_reg;
                REG_RISE:    rdata = {16'd0, rise_reg};
                REG_FALL:    rdata = {16'd0, fall_reg};
                REG_MASK:    rdata = {16'd0, mask_reg};
                REG_PENDING: rdata = {16'd0, pending_reg};
                default:     rdata = '0;
            endcase
        end
    end

    // Drive enable for each pin in general output mode
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            enables[i] = (mode_next[2*i +: 2] == MODE_OUTPUT);
        end
    end

    assign result.read_data    = rdata;
    assign result.pin_drive    = output_next;
    assign result.drive_enable = enables;
    assign result.irq          = |(pending_next & mask_next);

    // Hold state between requests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= '0;
            otype_reg   <= '0;
            speed_reg   <= '0;
            pull_reg    <= '0;
            input_reg   <= '0;
            output_reg  <= '0;
            alt_lo_reg  <= '0;
            alt_hi_reg  <= '0;
            rise_reg    <= '0;
            fall_reg    <= '0;
            mask_reg    <= '0;
            pending_reg <= '0;
            prev_reg    <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            otype_reg   <= otype_next;
            speed_reg   <= speed_next;
            pull_reg    <= pull_next;
            input_reg   <= input_next;
            output_reg  <= output_next;
            alt_lo_reg  <= alt_lo_next;
            alt_hi_reg  <= alt_hi_next;
            rise_reg    <= rise_next;
            fall_reg    <= fall_next;
            mask_reg    <= mask_next;
            pending_reg <= pending_next;
            prev_reg    <= prev_next;
        end
    end

    // A write of ones to pending clears those bits
    a_pending_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (apply && (req.command == CMD_WRITE) && (req.reg_index == REG_PENDING))
        |=> ((pending_reg & $past(wdata16)) == 16'd0))
        else $error("pending bits not cleared by write");

    // Pending only gains bits on a sample
    a_pending_rise: assert property (@(posedge clk) disable iff (!rst_n)
        !(apply && (req.command == CMD_SAMPLE))
        |=> ((pending_reg & ~$past(pending_reg)) == 16'd0))
        else $error("pending bit set without a sample");

    // The input register is read-only
    a_input_ro: assert property (@(posedge clk) disable iff (!rst_n)
        (apply && (req.command == CMD_WRITE) && (req.reg_index == REG_INPUT))
        |=> $stable(input_reg))
        else $error("input register changed by a write");

endmodule

`default_nettype wire
